/* design/order_book_price_level_table_assert.svh */
// Assertion macros for the order book price level table.
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_ASSERT_SVH
`ifndef SYNTH
`define OBPLT_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: check failed");
`define OBPLT_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: check failed");
`else
`define OBPLT_ASSERT_IMP(label, clk, rst, a, b)
`define OBPLT_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

/* design/obplt_pkg.sv */
// Shared types for the order book price level table.
package obplt_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FETCH,
    ST_APPLY,
    ST_BEST,
    ST_RESULT
  } st_t;

  typedef struct packed {
    logic capture;
    logic match_run;
    logic fetch;
    logic apply;
    logic best_run;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic match_done;
    logic best_done;
    logic out_free;
  } sts_t;
endpackage

/* design/obplt_ctrl.sv */
// Sequencer for one update: match scan, fetch, apply, best scan, result.
module obplt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output obplt_pkg::cmd_t  cmd,
  input  obplt_pkg::sts_t  sts
);
  import obplt_pkg::*;

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MATCH;
      ST_MATCH:  if (sts.match_done) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_BEST;
      ST_BEST:   if (sts.best_done) state_next = ST_RESULT;
      ST_RESULT: if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MATCH:  cmd.match_run = 1'b1;
      ST_FETCH:  cmd.fetch = 1'b1;
      ST_APPLY:  cmd.apply = 1'b1;
      ST_BEST:   cmd.best_run = 1'b1;
      ST_RESULT: cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end
endmodule

/* design/obplt_dp.sv */
// Level storage, scan logic, update arithmetic and result register.
`include "order_book_price_level_table_assert.svh"
module obplt_dp #(
  parameter int LEVELS_PER_SIDE = 64,
  parameter int PRICE_BITS = 32,
  parameter int VOLUME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  obplt_pkg::cmd_t    cmd,
  output obplt_pkg::sts_t    sts,
  input  logic               side,
  input  logic [31:0]        price,
  input  logic signed [47:0] vol_chg,
  input  logic signed [15:0] ord_chg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               level_present,
  output logic [47:0]        level_volume,
  output logic [15:0]        level_orders,
  output logic               table_full,
  output logic               top_bid_valid,
  output logic [31:0]        top_bid,
  output logic               top_ask_valid,
  output logic [31:0]        top_ask,
  output logic signed [32:0] spread,
  output logic [31:0]        midpoint
);
  import obplt_pkg::*;

  localparam int ENT = 2 * LEVELS_PER_SIDE;
  localparam int IW = $clog2(ENT);
  localparam int CNW = $clog2(ENT + 1);
  localparam int SPW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
  localparam int VW = VOLUME_BITS;
  localparam int AW = ((VW > 48) ? VW : 48) + 1;
  localparam logic [CNW-1:0] LCNT = CNW'(LEVELS_PER_SIDE);
  localparam logic [CNW-1:0] ECNT = CNW'(ENT);

  logic [SPW-1:0] price_mem [ENT];
  logic [VW-1:0]  vol_mem [ENT];
  logic [15:0]    ord_mem [ENT];
  logic [ENT-1:0] valid_q;

  logic           side_r;
  logic [SPW-1:0] price_r;
  logic           vneg, cneg;
  logic [47:0]    vmag;
  logic [15:0]    cmag;

  logic [CNW-1:0] cnt;
  logic [IW-1:0]  idx_d;
  logic           live_m, live_b;
  logic [SPW-1:0] rd_price;
  logic [VW-1:0]  rd_vol;
  logic [15:0]    rd_ord;

  logic           hit_found, free_found;
  logic [IW-1:0]  hit_idx, free_idx;
  logic           pres, full;
  logic [47:0]    lvol;
  logic [15:0]    lord;
  logic           bv, av;
  logic [SPW-1:0] bb, ba;

  logic [CNW-1:0] addr_w;
  logic [IW-1:0]  addr_c;
  logic           issue_m, issue_b;
  logic           two_sided;

  assign issue_m = cmd.match_run && (cnt < LCNT);
  assign issue_b = cmd.best_run && (cnt < ECNT);

  always_comb begin
    if (cmd.fetch) addr_w = CNW'(hit_idx);
    else if (cmd.best_run) addr_w = cnt;
    else addr_w = (side_r ? LCNT : '0) + cnt;
    addr_c = addr_w[IW-1:0];
  end

  // update arithmetic
  logic [AW-1:0] vcur_x, vmag_x, vmax_x, vsum, vnew_x;
  logic [16:0]   csum, cnew_x;
  logic [VW-1:0] vnew, vcreate;
  logic          create, emptied;

  always_comb begin
    vcur_x = AW'(rd_vol);
    vmag_x = AW'(vmag);
    vmax_x = AW'({VW{1'b1}});
    vsum = vcur_x + vmag_x;
    if (vneg) vnew_x = (vmag_x > vcur_x) ? '0 : vcur_x - vmag_x;
    else vnew_x = (vsum > vmax_x) ? vmax_x : vsum;
    vnew = vnew_x[VW-1:0];
    csum = {1'b0, rd_ord} + {1'b0, cmag};
    if (cneg) cnew_x = (cmag > rd_ord) ? '0 : {1'b0, rd_ord - cmag};
    else cnew_x = csum[16] ? 17'h0ffff : csum;
    vcreate = (vmag_x > vmax_x) ? vmax_x[VW-1:0] : vmag_x[VW-1:0];
    create = !vneg && (vmag != '0) && !cneg && (cmag != '0);
    emptied = (vnew == '0) || (cnew_x == '0);
  end

  always_ff @(posedge clk) begin
    rd_price <= price_mem[addr_c];
    rd_vol <= vol_mem[addr_c];
    rd_ord <= ord_mem[addr_c];
    idx_d <= addr_c;
    if (cmd.apply) begin
      if (hit_found && !emptied) begin
        vol_mem[hit_idx] <= vnew;
        ord_mem[hit_idx] <= cnew_x[15:0];
      end else if (!hit_found && create && free_found) begin
        price_mem[free_idx] <= price_r;
        vol_mem[free_idx] <= vcreate;
        ord_mem[free_idx] <= cmag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      side_r <= side;
      price_r <= price[SPW-1:0];
      vneg <= vol_chg[47];
      vmag <= vol_chg[47] ? 48'(~vol_chg + 48'sd1) : vol_chg;
      cneg <= ord_chg[15];
      cmag <= ord_chg[15] ? 16'(~ord_chg + 16'sd1) : ord_chg;
    end
    if (live_m) begin
      if (valid_q[idx_d]) begin
        if (!hit_found && rd_price == price_r) hit_idx <= idx_d;
      end else if (!free_found) begin
        free_idx <= idx_d;
      end
    end
    if (cmd.apply) begin
      pres <= hit_found ? !emptied : (create && free_found);
      full <= !hit_found && create && !free_found;
      if (hit_found && !emptied) begin
        lvol <= 48'(vnew);
        lord <= cnew_x[15:0];
      end else if (!hit_found && create && free_found) begin
        lvol <= 48'(vcreate);
        lord <= cmag;
      end else begin
        lvol <= '0;
        lord <= '0;
      end
    end
    if (live_b && valid_q[idx_d]) begin
      if (CNW'(idx_d) < LCNT) begin
        if (!bv || rd_price > bb) bb <= rd_price;
      end else begin
        if (!av || rd_price < ba) ba <= rd_price;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      cnt <= '0;
      live_m <= 1'b0;
      live_b <= 1'b0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
      bv <= 1'b0;
      av <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      live_m <= issue_m;
      live_b <= issue_b;
      if (cmd.capture || cmd.apply) cnt <= '0;
      else if (issue_m || issue_b) cnt <= cnt + 1'b1;
      if (cmd.capture) begin
        hit_found <= 1'b0;
        free_found <= 1'b0;
      end else if (live_m) begin
        if (valid_q[idx_d]) begin
          if (rd_price == price_r) hit_found <= 1'b1;
        end else begin
          free_found <= 1'b1;
        end
      end
      if (cmd.apply) begin
        bv <= 1'b0;
        av <= 1'b0;
        if (hit_found && emptied) valid_q[hit_idx] <= 1'b0;
        else if (!hit_found && create && free_found) valid_q[free_idx] <= 1'b1;
      end else if (live_b && valid_q[idx_d]) begin
        if (CNW'(idx_d) < LCNT) bv <= 1'b1;
        else av <= 1'b1;
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      level_present <= pres;
      level_volume <= lvol;
      level_orders <= lord;
      table_full <= full;
      top_bid_valid <= bv;
      top_ask_valid <= av;
      top_bid <= bv ? 32'(bb) : '0;
      top_ask <= av ? 32'(ba) : '0;
      spread <= (bv && av) ? 33'(33'(ba) - 33'(bb)) : '0;
      midpoint <= (bv && av) ? 32'((33'(bb) + 33'(ba)) >> 1) : '0;
    end
  end

  assign sts.match_done = (cnt == LCNT) && !live_m && cmd.match_run;
  assign sts.best_done = (cnt == ECNT) && !live_b && cmd.best_run;
  assign sts.out_free = !out_valid || !out_stall;
  assign two_sided = top_bid_valid && top_ask_valid;

  `OBPLT_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, !out_valid || !out_stall)
  `OBPLT_ASSERT_IMP(a_full_absent, clk, rst, out_valid, !(table_full && level_present))
  `OBPLT_ASSERT_IMP(a_no_mid, clk, rst, out_valid && !two_sided, spread == '0 && midpoint == '0)
  `OBPLT_ASSERT_NXT(a_fetch_apply, clk, rst, cmd.fetch, cmd.apply)
endmodule

/* design/order_book_price_level_table.sv */
// Top level of the order book price level table.
//
//  channel | valid     | stall     | beat fields
//  input   | in_valid  | in_stall  | side, price, vol_chg, ord_chg
//  output  | out_valid | out_stall | level_present .. midpoint
//
// Each beat runs a scan of the side's entries for the price and a free slot,
// one read and one write of the entry, then a scan of all entries for best bid
// and ask, one memory read per cycle. The result then loads into the output
// register once that register is free.
// A synchronous reset clears the valid bits; both tables are empty after reset.
// A new beat is taken while the previous result waits in the output register.
module order_book_price_level_table #(
  parameter int LEVELS_PER_SIDE = 64,
  parameter int PRICE_BITS = 32,
  parameter int VOLUME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               side,
  input  logic [31:0]        price,
  input  logic signed [47:0] vol_chg,
  input  logic signed [15:0] ord_chg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               level_present,
  output logic [47:0]        level_volume,
  output logic [15:0]        level_orders,
  output logic               table_full,
  output logic               top_bid_valid,
  output logic [31:0]        top_bid,
  output logic               top_ask_valid,
  output logic [31:0]        top_ask,
  output logic signed [32:0] spread,
  output logic [31:0]        midpoint
);
  import obplt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  obplt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  obplt_dp #(
    .LEVELS_PER_SIDE (LEVELS_PER_SIDE),
    .PRICE_BITS      (PRICE_BITS),
    .VOLUME_BITS     (VOLUME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .side           (side),
    .price          (price),
    .vol_chg        (vol_chg),
    .ord_chg        (ord_chg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .level_present  (level_present),
    .level_volume   (level_volume),
    .level_orders   (level_orders),
    .table_full     (table_full),
    .top_bid_valid  (top_bid_valid),
    .top_bid        (top_bid),
    .top_ask_valid  (top_ask_valid),
    .top_ask        (top_ask),
    .spread         (spread),
    .midpoint       (midpoint)
  );
endmodule
